[src/fvnh_pkg.sv]
package fvnh_pkg;

  localparam int FRAC_BITS = 20;
  localparam int COS_TABLE_SIZE = 256;
  localparam logic [31:0] HASH_C1 = 32'd15731;
  localparam logic [31:0] HASH_C2 = 32'd789221;
  localparam logic [31:0] HASH_C3 = 32'd1376312589;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd1;
  localparam logic [1:0] REG_BASE_HEIGHT  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIVX,
    ST_WAITX,
    ST_DIVZ,
    ST_WAITZ,
    ST_TBL,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_H4,
    ST_SMOOTH,
    ST_B0,
    ST_B1,
    ST_B2,
    ST_B3,
    ST_B4,
    ST_FIN,
    ST_HT,
    ST_DONE
  } state_t;

  // shift right with truncation toward zero
  function automatic logic signed [47:0] trunc_shift(input logic signed [47:0] v,
                                                     input logic [5:0] s);
    logic signed [47:0] mag;
    mag = v[47] ? -v : v;
    mag = mag >>> s;
    return v[47] ? -mag : mag;
  endfunction

  // sin^2 weight in q20 for table entry k of 2^lg entries
  function automatic logic [20:0] cos_weight(input int unsigned k, input int unsigned lg);
    longint unsigned phi;
    longint unsigned p2;
    longint unsigned one;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    phi = (HALF_PI_Q30 * longint'(k)) >> lg;
    p2 = (phi * phi) >> 30;
    one = 64'd1 << 30;
    t = one - p2 / 110;
    t = one - ((p2 * t) >> 30) / 72;
    t = one - ((p2 * t) >> 30) / 42;
    t = one - ((p2 * t) >> 30) / 20;
    t = one - ((p2 * t) >> 30) / 6;
    s = (phi * t) >> 30;
    r = (s * s) >> 40;
    return r[20:0];
  endfunction

endpackage

[src/fvnh_div5.sv]
module fvnh_div5 #(
  parameter int W = 44
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [16:0]  mag,
  input  logic [5:0]   shift,
  output logic         done,
  output logic [W-1:0] quotient
);

  // floor(mag * 2^shift / 5): with mag = 5a + r this is a * 2^shift plus
  // floor(r * 2^smax / 5) >> (smax - shift)
  localparam int SMAX = W - 17;
  localparam logic [W-1:0] R1 = W'((64'd1 << SMAX) / 64'd5);
  localparam logic [W-1:0] R2 = W'((64'd2 << SMAX) / 64'd5);
  localparam logic [W-1:0] R3 = W'((64'd3 << SMAX) / 64'd5);
  localparam logic [W-1:0] R4 = W'((64'd4 << SMAX) / 64'd5);
  localparam logic [15:0] RECIP5 = 16'd52429;

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [16:0]  mag_r, mag_nxt;
  logic [5:0]   sh_r, sh_nxt;
  logic [14:0]  a_r, a_nxt;
  logic [W-1:0] q_r, q_nxt;
  logic [32:0]  recip;
  logic [16:0]  five_a;
  logic [2:0]   rem;
  logic [W-1:0] frac_q;

  always_comb begin
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    mag_nxt  = mag_r;
    sh_nxt   = sh_r;
    a_nxt    = a_r;
    q_nxt    = q_r;
    // exact quotient by 5 for any 17-bit mag
    recip  = 33'(mag) * 33'(RECIP5);
    five_a = (17'(a_r) << 2) + 17'(a_r);
    rem    = 3'(mag_r - five_a);
    case (rem)
      3'd1:    frac_q = R1;
      3'd2:    frac_q = R2;
      3'd3:    frac_q = R3;
      3'd4:    frac_q = R4;
      default: frac_q = '0;
    endcase
    if (start) begin
      busy_nxt = 1'b1;
      mag_nxt  = mag;
      sh_nxt   = shift;
      a_nxt    = recip[32:18];
    end else if (busy_r) begin
      q_nxt    = (W'(a_r) << sh_r) + (frac_q >> (6'(SMAX) - sh_r));
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mag_r <= mag_nxt;
    sh_r  <= sh_nxt;
    a_r   <= a_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[src/fractal_value_noise_height.sv]
// channel  dir  signals                         beat
// in       in   in_tvalid/in_tready/in_tdata    one column (col_x, col_z)
// out      out  out_tvalid/out_tready/out_tdata one surface_height
// cfg      in   cfg_we/cfg_addr/cfg_wdata       one register write
// per octave: two divides by 5, one table read, then 4 lattice points, each of 9 hashes
// (states H0 to H4) and one smoothing step, the hashes on the shared multiplier, then blend states B0 to B4
// in_tready is high only while idle; a finished height waits in the output register
// and the next column may be taken meanwhile; the done state stalls while that register
// still holds an unaccepted beat; synchronous active-low reset
module fractal_value_noise_height #(
  parameter int MAX_OCTAVES    = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // col_x [15:0], col_z [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // surface_height [8:0], zero [15:9]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata
);

  localparam int LG   = $clog2(fvnh_pkg::COS_TABLE_SIZE);
  localparam int OW   = $clog2(MAX_OCTAVES + 1);
  localparam int DIVW = 34 + MAX_OCTAVES;
  localparam int LW   = DIVW - fvnh_pkg::FRAC_BITS;

  logic [20:0] cos_tbl [fvnh_pkg::COS_TABLE_SIZE];
  for (genvar g = 0; g < fvnh_pkg::COS_TABLE_SIZE; g++) begin : g_tbl
    assign cos_tbl[g] = fvnh_pkg::cos_weight(g, LG);
  end

  fvnh_pkg::state_t state_r, state_nxt;
  logic [3:0]  oct_cnt_r;
  logic [7:0]  scale_r;
  logic [8:0]  base_r;
  logic signed [15:0] x_r, x_nxt, z_r, z_nxt;
  logic [OW-1:0] octs_r, octs_nxt, oct_i_r, oct_i_nxt;
  logic signed [23:0] total_r, total_nxt;
  logic [31:0] lx_r, lx_nxt, lz_r, lz_nxt;
  logic [LG-1:0] kx_r, kx_nxt, kz_r, kz_nxt;
  logic [20:0] wx_r, wx_nxt, wz_r, wz_nxt;
  logic [1:0]  pt_r, pt_nxt, jx_r, jx_nxt, jz_r, jz_nxt;
  logic [31:0] n_r, n_nxt;
  logic signed [26:0] acc_r, acc_nxt;
  logic signed [21:0] v_r [4];
  logic signed [21:0] v_nxt [4];
  logic signed [21:0] bl0_r, bl0_nxt, bl1_r, bl1_nxt;
  logic signed [65:0] prod_r;
  logic signed [32:0] mul_a, mul_b;
  logic [8:0]  res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        div_start, div_done;
  logic [16:0] div_in;
  logic [5:0]  div_sh;
  logic [DIVW-1:0] div_q;
  logic signed [16:0] col_ext, col_mag;
  logic [31:0] lmag, hx, hz, n0, m;
  logic signed [21:0] noise;
  logic [1:0]  nshift;
  logic signed [22:0] diff;
  logic signed [47:0] bsum, tsh;
  logic signed [33:0] hs;
  logic signed [13:0] hfl;

  fvnh_div5 #(.W(DIVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .mag      (div_in),
    .shift    (div_sh),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= 4'd8;
      scale_r   <= 8'd30;
      base_r    <= 9'd128;
    end else if (cfg_we) begin
      case (cfg_addr)
        fvnh_pkg::REG_OCTAVE_COUNT: oct_cnt_r <= cfg_wdata[3:0];
        fvnh_pkg::REG_HEIGHT_SCALE: scale_r   <= cfg_wdata[7:0];
        fvnh_pkg::REG_BASE_HEIGHT:  base_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    z_nxt = z_r;
    octs_nxt = octs_r;
    oct_i_nxt = oct_i_r;
    total_nxt = total_r;
    lx_nxt = lx_r;
    lz_nxt = lz_r;
    kx_nxt = kx_r;
    kz_nxt = kz_r;
    wx_nxt = wx_r;
    wz_nxt = wz_r;
    pt_nxt = pt_r;
    jx_nxt = jx_r;
    jz_nxt = jz_r;
    n_nxt = n_r;
    acc_nxt = acc_r;
    v_nxt = v_r;
    bl0_nxt = bl0_r;
    bl1_nxt = bl1_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;

    col_ext = (state_r == fvnh_pkg::ST_DIVZ) ? {z_r[15], z_r} : {x_r[15], x_r};
    col_mag = col_ext[16] ? -col_ext : col_ext;
    div_in = col_mag;
    div_sh = 6'd18 + 6'(oct_i_r);
    lmag = {{(32-LW){1'b0}}, div_q[DIVW-1:fvnh_pkg::FRAC_BITS]};

    hx = lx_r + 32'(pt_r[0]) + 32'(jx_r) - 32'd1;
    hz = lz_r + 32'(pt_r[1]) + 32'(jz_r) - 32'd1;
    n0 = hx + (hz << 6) - (hz << 3) + hz;
    m = prod_r[31:0] + fvnh_pkg::HASH_C3;
    noise = 22'sd1048576 - $signed({1'b0, m[30:10]});
    // centre counts 4, sides 2, corners 1
    nshift = 2'((jx_r == 2'd1) ? 1 : 0) + 2'((jz_r == 2'd1) ? 1 : 0);
    diff = '0;
    bsum = '0;
    tsh = '0;
    hs = '0;
    hfl = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      fvnh_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt = in_tdata[15:0];
          z_nxt = in_tdata[31:16];
          octs_nxt = (32'(oct_cnt_r) > MAX_OCTAVES) ? OW'(MAX_OCTAVES) : OW'(oct_cnt_r);
          oct_i_nxt = '0;
          total_nxt = '0;
          state_nxt = (oct_cnt_r == 4'd0) ? fvnh_pkg::ST_FIN : fvnh_pkg::ST_DIVX;
        end
      end
      fvnh_pkg::ST_DIVX: begin
        div_start = 1'b1;
        state_nxt = fvnh_pkg::ST_WAITX;
      end
      fvnh_pkg::ST_WAITX: begin
        if (div_done) begin
          lx_nxt = x_r[15] ? -lmag : lmag;
          kx_nxt = div_q[fvnh_pkg::FRAC_BITS-1 -: LG];
          state_nxt = fvnh_pkg::ST_DIVZ;
        end
      end
      fvnh_pkg::ST_DIVZ: begin
        div_start = 1'b1;
        state_nxt = fvnh_pkg::ST_WAITZ;
      end
      fvnh_pkg::ST_WAITZ: begin
        if (div_done) begin
          lz_nxt = z_r[15] ? -lmag : lmag;
          kz_nxt = div_q[fvnh_pkg::FRAC_BITS-1 -: LG];
          state_nxt = fvnh_pkg::ST_TBL;
        end
      end
      fvnh_pkg::ST_TBL: begin
        wx_nxt = cos_tbl[kx_r];
        wz_nxt = cos_tbl[kz_r];
        pt_nxt = '0;
        jx_nxt = '0;
        jz_nxt = '0;
        acc_nxt = '0;
        state_nxt = fvnh_pkg::ST_H0;
      end
      fvnh_pkg::ST_H0: begin
        n_nxt = (n0 << 13) ^ n0;
        state_nxt = fvnh_pkg::ST_H1;
      end
      fvnh_pkg::ST_H1: begin
        mul_a = {1'b0, n_r};
        mul_b = {1'b0, n_r};
        state_nxt = fvnh_pkg::ST_H2;
      end
      fvnh_pkg::ST_H2: begin
        mul_a = {1'b0, prod_r[31:0]};
        mul_b = {1'b0, fvnh_pkg::HASH_C1};
        state_nxt = fvnh_pkg::ST_H3;
      end
      fvnh_pkg::ST_H3: begin
        mul_a = {1'b0, n_r};
        mul_b = {1'b0, prod_r[31:0] + fvnh_pkg::HASH_C2};
        state_nxt = fvnh_pkg::ST_H4;
      end
      fvnh_pkg::ST_H4: begin
        acc_nxt = acc_r + (27'(noise) <<< nshift);
        state_nxt = fvnh_pkg::ST_H0;
        if (jx_r == 2'd2) begin
          jx_nxt = '0;
          if (jz_r == 2'd2) begin
            jz_nxt = '0;
            state_nxt = fvnh_pkg::ST_SMOOTH;
          end else begin
            jz_nxt = jz_r + 2'd1;
          end
        end else begin
          jx_nxt = jx_r + 2'd1;
        end
      end
      fvnh_pkg::ST_SMOOTH: begin
        tsh = fvnh_pkg::trunc_shift(48'(acc_r), 6'd4);
        v_nxt[pt_r] = tsh[21:0];
        acc_nxt = '0;
        if (pt_r == 2'd3) begin
          state_nxt = fvnh_pkg::ST_B0;
        end else begin
          pt_nxt = pt_r + 2'd1;
          state_nxt = fvnh_pkg::ST_H0;
        end
      end
      fvnh_pkg::ST_B0: begin
        diff = 23'(v_r[1]) - 23'(v_r[0]);
        mul_a = 33'(diff);
        mul_b = {12'b0, wx_r};
        state_nxt = fvnh_pkg::ST_B1;
      end
      fvnh_pkg::ST_B1: begin
        bsum = (48'(v_r[0]) <<< 20) + 48'($signed(prod_r[43:0]));
        tsh = fvnh_pkg::trunc_shift(bsum, 6'd20);
        bl0_nxt = tsh[21:0];
        diff = 23'(v_r[3]) - 23'(v_r[2]);
        mul_a = 33'(diff);
        mul_b = {12'b0, wx_r};
        state_nxt = fvnh_pkg::ST_B2;
      end
      fvnh_pkg::ST_B2: begin
        bsum = (48'(v_r[2]) <<< 20) + 48'($signed(prod_r[43:0]));
        tsh = fvnh_pkg::trunc_shift(bsum, 6'd20);
        bl1_nxt = tsh[21:0];
        state_nxt = fvnh_pkg::ST_B3;
      end
      fvnh_pkg::ST_B3: begin
        diff = 23'(bl1_r) - 23'(bl0_r);
        mul_a = 33'(diff);
        mul_b = {12'b0, wz_r};
        state_nxt = fvnh_pkg::ST_B4;
      end
      fvnh_pkg::ST_B4: begin
        bsum = (48'(bl0_r) <<< 20) + 48'($signed(prod_r[43:0]));
        tsh = fvnh_pkg::trunc_shift(bsum, 6'd20);
        tsh = fvnh_pkg::trunc_shift(48'($signed(tsh[21:0])), 6'({oct_i_r, 1'b0}));
        total_nxt = total_r + tsh[23:0];
        if (oct_i_r + OW'(1) == octs_r) begin
          state_nxt = fvnh_pkg::ST_FIN;
        end else begin
          oct_i_nxt = oct_i_r + OW'(1);
          state_nxt = fvnh_pkg::ST_DIVX;
        end
      end
      fvnh_pkg::ST_FIN: begin
        mul_a = 33'(total_r);
        mul_b = {25'b0, scale_r};
        state_nxt = fvnh_pkg::ST_HT;
      end
      fvnh_pkg::ST_HT: begin
        // arithmetic shift floors, which matches the rounding of a negative height
        hs = 34'($signed(prod_r[31:0])) + {5'b0, base_r, 20'b0};
        hfl = hs[33:20];
        if (hfl < 0) res_nxt = 9'd0;
        else if (hfl > 14'sd511) res_nxt = 9'd511;
        else res_nxt = hfl[8:0];
        state_nxt = fvnh_pkg::ST_DONE;
      end
      fvnh_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt = fvnh_pkg::ST_IDLE;
        end else begin
          res_nxt = res_r;
        end
      end
      default: state_nxt = fvnh_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fvnh_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r     <= x_nxt;
    z_r     <= z_nxt;
    octs_r  <= octs_nxt;
    oct_i_r <= oct_i_nxt;
    total_r <= total_nxt;
    lx_r    <= lx_nxt;
    lz_r    <= lz_nxt;
    kx_r    <= kx_nxt;
    kz_r    <= kz_nxt;
    wx_r    <= wx_nxt;
    wz_r    <= wz_nxt;
    pt_r    <= pt_nxt;
    jx_r    <= jx_nxt;
    jz_r    <= jz_nxt;
    n_r     <= n_nxt;
    acc_r   <= acc_nxt;
    v_r     <= v_nxt;
    bl0_r   <= bl0_nxt;
    bl1_r   <= bl1_nxt;
    prod_r  <= mul_a * mul_b;
  end

  // the held result only changes when a new one is loaded in the done state
  logic [8:0] out_hold_r;
  always_ff @(posedge clk) begin
    if (state_r == fvnh_pkg::ST_DONE && (!out_valid_r || out_tready)) out_hold_r <= res_r;
    res_r <= res_nxt;
  end

  assign in_tready  = (state_r == fvnh_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_hold_r};

endmodule

[src/fvnh_checker.sv]
module fvnh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("column taken while still working");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0)
    else $error("height padding not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

endmodule

bind fractal_value_noise_height fvnh_checker u_fvnh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/tb_top.sv]
module tb_top;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_COLUMNS = 1550;
  localparam longint CYCLE_LIMIT = 64'd30000000;
  localparam longint ONE_Q20 = 64'd1 << fvnh_pkg::FRAC_BITS;

  class height_board;
    int unsigned octaves;
    int unsigned scale;
    int unsigned base;
    logic [8:0] pending_heights[$];
    int mismatches;

    function new();
      octaves = 8;
      scale = 30;
      base = 128;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        fvnh_pkg::REG_OCTAVE_COUNT: octaves = 32'(val[3:0]);
        fvnh_pkg::REG_HEIGHT_SCALE: scale = 32'(val[7:0]);
        fvnh_pkg::REG_BASE_HEIGHT: base = 32'(val[8:0]);
        default: ;
      endcase
    endfunction

    function longint shr_zero(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v) >>> s);
    endfunction

    function longint hash_noise(longint x, longint z);
      bit [31:0] n;
      bit [31:0] m;
      n = 32'(x) + 32'(z) * 32'd57;
      n = (n << 13) ^ n;
      m = n * (n * n * fvnh_pkg::HASH_C1 + fvnh_pkg::HASH_C2) + fvnh_pkg::HASH_C3;
      m = m & 32'h7fffffff;
      return ONE_Q20 - longint'(m >> 10);
    endfunction

    function longint smooth_noise(longint x, longint z);
      longint corners;
      longint sides;
      corners = hash_noise(x - 1, z - 1) + hash_noise(x + 1, z - 1)
              + hash_noise(x - 1, z + 1) + hash_noise(x + 1, z + 1);
      sides = hash_noise(x - 1, z) + hash_noise(x + 1, z)
            + hash_noise(x, z - 1) + hash_noise(x, z + 1);
      return shr_zero(4 * hash_noise(x, z) + 2 * sides + corners, 4);
    endfunction

    // sin^2 by a taylor series in q30, 256 table entries
    function longint blend_weight(longint frac);
      longint unsigned af;
      longint unsigned k;
      longint unsigned phi;
      longint unsigned p2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned one;
      af = (frac < 0) ? -frac : frac;
      k = (af * 256) >> fvnh_pkg::FRAC_BITS;
      if (k >= 256) k = 255;
      one = 64'd1 << 30;
      phi = fvnh_pkg::HALF_PI_Q30 * k / 256;
      p2 = (phi * phi) >> 30;
      t = one - p2 / 110;
      t = one - ((p2 * t) >> 30) / 72;
      t = one - ((p2 * t) >> 30) / 42;
      t = one - ((p2 * t) >> 30) / 20;
      t = one - ((p2 * t) >> 30) / 6;
      s = (phi * t) >> 30;
      return longint'((s * s) >> 40);
    endfunction

    function longint mix(longint a, longint b, longint w);
      return shr_zero(a * (ONE_Q20 - w) + b * w, fvnh_pkg::FRAC_BITS);
    endfunction

    function longint octave_sample(longint cx, longint cz);
      longint lx;
      longint lz;
      longint wx;
      longint wz;
      lx = cx / ONE_Q20;
      lz = cz / ONE_Q20;
      wx = blend_weight(cx - lx * ONE_Q20);
      wz = blend_weight(cz - lz * ONE_Q20);
      return mix(mix(smooth_noise(lx, lz), smooth_noise(lx + 1, lz), wx),
                 mix(smooth_noise(lx, lz + 1), smooth_noise(lx + 1, lz + 1), wx), wz);
    endfunction

    function void note_column(logic signed [15:0] col_x, logic signed [15:0] col_z);
      longint total;
      longint h;
      longint mult;
      int unsigned octs;
      total = 0;
      octs = (octaves > 10) ? 10 : octaves;
      for (int i = 0; i < octs; i++) begin
        mult = 64'd1 << (fvnh_pkg::FRAC_BITS + i);
        total += shr_zero(octave_sample(longint'(col_x) * mult / 20,
                                        longint'(col_z) * mult / 20), 2 * i);
      end
      h = total * longint'(scale) + longint'(base) * ONE_Q20;
      h = h >>> fvnh_pkg::FRAC_BITS;
      if (h < 0) h = 0;
      if (h > 511) h = 511;
      pending_heights.push_back(h[8:0]);
    endfunction

    function void check_height(logic [15:0] beat);
      logic [8:0] want;
      if (pending_heights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected height beat %0d", beat[8:0]);
        return;
      end
      want = pending_heights.pop_front();
      if (beat !== {7'd0, want}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("height mismatch: expected %0d, got %0d", want, beat);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [8:0]  cfg_wdata;

  height_board board;
  longint cycles;
  int burst_left;
  int rx_mode;

  fractal_value_noise_height i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    board = new();
    cycles = 0;
    rx_mode = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // accepted beats on both sides
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_column(in_tdata[15:0], in_tdata[31:16]);
    if (rst_n && out_tvalid && out_tready) board.check_height(out_tdata);
  end

  // receiver stall pattern, mode picked anew whenever the low byte of the cycle count is zero
  always @(posedge clk) begin
    if (cycles[7:0] == 8'd0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (cycles[4:0] == 5'd0);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    board.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_terrain(int unsigned octs, int unsigned scl, int unsigned bas);
    write_reg(fvnh_pkg::REG_OCTAVE_COUNT, 9'(octs));
    write_reg(fvnh_pkg::REG_HEIGHT_SCALE, 9'(scl));
    write_reg(fvnh_pkg::REG_BASE_HEIGHT, 9'(bas));
  endtask

  task automatic send_column(logic [15:0] col_x, logic [15:0] col_z);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {col_z, col_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap = $urandom_range(0, 4) * $urandom_range(0, 1) * 40;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap + $urandom_range(0, 39)) @(posedge clk);
      end
    end
  endtask

  // hold off until every height has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_heights.size() != 0) @(posedge clk);
  endtask

  logic [15:0] rand_coord;

  initial begin
    int sent;
    int unsigned octs;
    int pick;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers, coordinate extremes
    send_column(16'h8000, 16'h8000);
    send_column(16'h7fff, 16'h7fff);
    send_column(16'h8000, 16'h7fff);
    send_column(16'h0000, 16'h0000);
    send_column(16'hffff, 16'h0001);
    send_column(16'h0001, 16'hffff);
    drain();
    // zero octaves gives the base height
    set_terrain(0, 255, 511);
    send_column(16'h1234, 16'hfedc);
    send_column(16'h7fff, 16'h8000);
    drain();
    // count above the octave limit, max scale
    set_terrain(15, 255, 0);
    send_column(16'hfff0, 16'h0013);
    send_column(16'h5555, 16'haaaa);
    drain();
    set_terrain(1, 255, 0);
    for (int i = 0; i < 6; i++) send_column(16'($urandom), 16'($urandom));
    drain();
    set_terrain(1, 255, 511);
    for (int i = 0; i < 4; i++) send_column(16'($urandom), 16'($urandom));
    drain();
    // out-of-range register index must be ignored
    set_terrain(1, 0, 37);
    write_reg(REG_UNUSED, 9'h1ff);
    send_column(16'h0abc, 16'hf00d);
    drain();

    sent = 0;
    while (sent < RANDOM_COLUMNS) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) octs = 1;
      else if (pick < 17) octs = $urandom_range(2, 3);
      else if (pick < 18) octs = 0;
      else octs = $urandom_range(4, 15);
      set_terrain(octs, $urandom_range(0, 255), $urandom_range(0, 511));
      for (int i = 0; i < 40 && sent < RANDOM_COLUMNS; i++) begin
        if ($urandom_range(0, 3) == 0) rand_coord = 16'($urandom_range(0, 64) - 32);
        else rand_coord = 16'($urandom);
        send_column(rand_coord, 16'($urandom));
        sent++;
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (board.mismatches == 0 && board.pending_heights.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/fvnh_pkg.sv
src/fvnh_div5.sv
src/fractal_value_noise_height.sv
src/fvnh_checker.sv
test/tb_top.sv
